FILE: hdl/dspg_pkg.sv
// shared types, constants and codes for the dual stepper pulse generator
package dspg_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SPU_BITS   = 8;
    localparam int REM_BITS   = COUNT_BITS + SPU_BITS;
    localparam int WAIT_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [WAIT_BITS-1:0] STEP_DELAY_RESET     = WAIT_BITS'(100);
    localparam logic [SPU_BITS-1:0]  STEPS_PER_UNIT_RESET = SPU_BITS'(200);

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_MOVE_LEFT  = 2'd1,
        OP_MOVE_RIGHT = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STEP_DELAY     = 1'b0,
        CFG_STEPS_PER_UNIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [WAIT_BITS-1:0] step_delay;
        logic [SPU_BITS-1:0]  steps_per_unit;
    } cfg_t;

    // per-channel command derived from one request
    typedef struct packed {
        logic                         tick;
        logic                         load;
        logic signed [COUNT_BITS-1:0] count;
        logic signed [COUNT_BITS-1:0] queued;
    } chan_cmd_t;

    // per-channel line levels and stop pulse after the request
    typedef struct packed {
        logic step;
        logic dir;
        logic stopped;
    } chan_res_t;

endpackage

FILE: hdl/dspg_channel.sv
// one step/direction channel: remaining count, queued move and idle delay timer
module dspg_channel
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  dspg_pkg::cfg_t    cfg,
    input  dspg_pkg::chan_cmd_t cmd,
    output dspg_pkg::chan_res_t res
);

    logic [dspg_pkg::REM_BITS-1:0]   rem_reg,  rem_next;
    logic [dspg_pkg::COUNT_BITS-1:0] pend_reg, pend_next;
    logic [dspg_pkg::WAIT_BITS-1:0]  wait_reg, wait_next;
    logic                            dir_reg,  dir_next;
    logic                            step_reg, step_next;
    logic                            stopped;

    logic [dspg_pkg::COUNT_BITS-1:0] src;
    logic                            src_neg;
    logic [dspg_pkg::COUNT_BITS-1:0] mag;
    logic [dspg_pkg::REM_BITS-1:0]   load_rem;
    logic                            load_dir;
    logic [dspg_pkg::WAIT_BITS-1:0]  wait_dec;

    // move source: the request's count, or the queued count on a delayed start
    assign src      = cmd.load ? dspg_pkg::COUNT_BITS'(cmd.count) : pend_reg;
    assign src_neg  = src[dspg_pkg::COUNT_BITS-1];
    assign mag      = src_neg ? dspg_pkg::COUNT_BITS'(~src + 1'b1) : src;
    assign load_rem = dspg_pkg::REM_BITS'(mag) * dspg_pkg::REM_BITS'(cfg.steps_per_unit);
    assign load_dir = !src_neg && (src != '0);
    assign wait_dec = (wait_reg != '0) ? wait_reg - dspg_pkg::WAIT_BITS'(1) : '0;

    always_comb
    begin
        rem_next  = rem_reg;
        pend_next = pend_reg;
        wait_next = wait_reg;
        dir_next  = dir_reg;
        step_next = step_reg;
        stopped   = 1'b0;
        if (cmd.load)
        begin
            rem_next  = load_rem;
            pend_next = dspg_pkg::COUNT_BITS'(cmd.queued);
            wait_next = cfg.step_delay;
            dir_next  = load_dir;
        end
        else if (cmd.tick)
        begin
            if (rem_reg != '0)
            begin
                // high on even counts, low on odd
                step_next = ~rem_reg[0];
                rem_next  = rem_reg - dspg_pkg::REM_BITS'(1);
                stopped   = (rem_reg == dspg_pkg::REM_BITS'(1)) && (pend_reg == '0);
            end
            else
            begin
                step_next = 1'b0;
                if (wait_dec == '0)
                begin
                    rem_next  = load_rem;
                    pend_next = '0;
                    wait_next = cfg.step_delay;
                    dir_next  = load_dir;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            pend_reg <= '0;
            wait_reg <= '0;
            dir_reg  <= 1'b0;
            step_reg <= 1'b0;
        end
        else if (en)
        begin
            rem_reg  <= rem_next;
            pend_reg <= pend_next;
            wait_reg <= wait_next;
            dir_reg  <= dir_next;
            step_reg <= step_next;
        end
    end

    assign res.step    = step_next;
    assign res.dir     = dir_next;
    assign res.stopped = stopped;

    // last half-step of a run with nothing queued leaves the channel idle, line low
    a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !cmd.load && cmd.tick && rem_reg == dspg_pkg::REM_BITS'(1) && pend_reg == '0)
        |=> (rem_reg == '0 && !step_reg))
        else $error("stop did not leave channel idle");

    // a move restarts the delay timer
    a_load_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmd.load) |=> (wait_reg == $past(cfg.step_delay)))
        else $error("move did not restart delay timer");

    // state only moves when a request is processed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(rem_reg) && $stable(pend_reg) && $stable(wait_reg)))
        else $error("channel state changed without a request");

endmodule

FILE: hdl/dual_stepper_pulse_generator_core.sv
// top level of the dual stepper step/direction pulse generator
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  req     | req_valid req_ready operation move_count      | in
//          | queued_count                                  |
//  res     | res_valid res_ready left_step left_dir        | out
//          | right_step right_dir left_stopped right_stopped|
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data        | in
//
//  each request passes through the request register, then through the channel
//  update into the result register; one request per cycle is sustained while
//  res_ready is high, and the channel state update is the only loop
//  the request register accepts while a result waits, so a stalled result side
//  blocks new requests only once both registers are full
//  reset clears all channel state and loads the register reset values;
//  configuration writes are always taken (cfg_ready stays high)
module dual_stepper_pulse_generator_core
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    // request channel
    input  logic                                     req_valid,
    output logic                                     req_ready,
    input  logic [1:0]                               operation,
    input  logic signed [dspg_pkg::COUNT_BITS-1:0]   move_count,
    input  logic signed [dspg_pkg::COUNT_BITS-1:0]   queued_count,
    // result channel
    output logic                                     res_valid,
    input  logic                                     res_ready,
    output logic                                     left_step,
    output logic                                     left_dir,
    output logic                                     right_step,
    output logic                                     right_dir,
    output logic                                     left_stopped,
    output logic                                     right_stopped,
    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [dspg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [dspg_pkg::WAIT_BITS-1:0]           cfg_data
);

    // configuration registers
    dspg_pkg::cfg_t cfg_reg;

    // request register
    logic                                   req_vld_reg;
    logic [1:0]                             op_reg;
    logic signed [dspg_pkg::COUNT_BITS-1:0] move_reg;
    logic signed [dspg_pkg::COUNT_BITS-1:0] queued_reg;

    // result register
    logic                  res_valid_reg;
    dspg_pkg::chan_res_t   left_res_reg;
    dspg_pkg::chan_res_t   right_res_reg;

    dspg_pkg::chan_cmd_t   left_cmd;
    dspg_pkg::chan_cmd_t   right_cmd;
    dspg_pkg::chan_res_t   left_res;
    dspg_pkg::chan_res_t   right_res;
    logic                  adv;

    assign cfg_ready = 1'b1;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_delay     <= dspg_pkg::STEP_DELAY_RESET;
            cfg_reg.steps_per_unit <= dspg_pkg::STEPS_PER_UNIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (dspg_pkg::cfg_index_t'(cfg_index))
                dspg_pkg::CFG_STEP_DELAY:
                    cfg_reg.step_delay <= cfg_data;
                dspg_pkg::CFG_STEPS_PER_UNIT:
                    cfg_reg.steps_per_unit <= dspg_pkg::SPU_BITS'(cfg_data);
                default: ;
            endcase
        end
    end

    // the held request moves on when the result register is free or being drained
    assign adv       = req_vld_reg && (!res_valid_reg || res_ready);
    assign req_ready = !req_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (req_ready)
            req_vld_reg <= req_valid;
    end

    // request payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            op_reg     <= operation;
            move_reg   <= move_count;
            queued_reg <= queued_count;
        end
    end

    // operation decode; the unused code touches neither channel
    always_comb
    begin
        left_cmd.tick    = 1'b0;
        left_cmd.load    = 1'b0;
        left_cmd.count   = move_reg;
        left_cmd.queued  = queued_reg;
        right_cmd.tick   = 1'b0;
        right_cmd.load   = 1'b0;
        right_cmd.count  = move_reg;
        right_cmd.queued = queued_reg;
        unique case (op_reg)
            dspg_pkg::OP_TICK:
            begin
                left_cmd.tick  = 1'b1;
                right_cmd.tick = 1'b1;
            end
            dspg_pkg::OP_MOVE_LEFT:
                left_cmd.load = 1'b1;
            dspg_pkg::OP_MOVE_RIGHT:
                right_cmd.load = 1'b1;
            default: ;
        endcase
    end

    dspg_channel u_left
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .cfg   (cfg_reg),
        .cmd   (left_cmd),
        .res   (left_res)
    );

    dspg_channel u_right
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .cfg   (cfg_reg),
        .cmd   (right_cmd),
        .res   (right_res)
    );

    // result valid: set by an advancing request, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    // result payload captured alongside the channel state update
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            left_res_reg  <= left_res;
            right_res_reg <= right_res;
        end
    end

    assign res_valid     = res_valid_reg;
    assign left_step     = left_res_reg.step;
    assign left_dir      = left_res_reg.dir;
    assign right_step    = right_res_reg.step;
    assign right_dir     = right_res_reg.dir;
    assign left_stopped  = left_res_reg.stopped;
    assign right_stopped = right_res_reg.stopped;

endmodule

FILE: tb/dual_stepper_pulse_generator_checker.sv
// request/result checker with line-level predictor for the dual stepper pulse generator
module dual_stepper_pulse_generator_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    input  logic                                   req_ready,
    input  logic [1:0]                             operation,
    input  logic signed [dspg_pkg::COUNT_BITS-1:0] move_count,
    input  logic signed [dspg_pkg::COUNT_BITS-1:0] queued_count,
    input  logic                                   res_valid,
    input  logic                                   res_ready,
    input  logic                                   left_step,
    input  logic                                   left_dir,
    input  logic                                   right_step,
    input  logic                                   right_dir,
    input  logic                                   left_stopped,
    input  logic                                   right_stopped,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [dspg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dspg_pkg::WAIT_BITS-1:0]         cfg_data,
    output int                                     results_checked,
    output int                                     level_errors
);

    typedef struct packed {
        logic [dspg_pkg::REM_BITS-1:0]   remaining;
        logic [dspg_pkg::COUNT_BITS-1:0] pending;
        logic [dspg_pkg::WAIT_BITS-1:0]  idle_timer;
        logic                            dir;
        logic                            step;
        logic                            stopped;
    } motor_t;

    typedef struct packed {
        logic left_step;
        logic left_dir;
        logic right_step;
        logic right_dir;
        logic left_stopped;
        logic right_stopped;
    } levels_t;

    logic [dspg_pkg::WAIT_BITS-1:0] step_delay;
    logic [dspg_pkg::SPU_BITS-1:0]  steps_per_unit;
    motor_t                         left_motor;
    motor_t                         right_motor;
    levels_t                        expected_levels_q[$];

    // load a run: direction from sign, half-steps from magnitude, timer restarted
    function automatic motor_t with_move(motor_t m, logic [dspg_pkg::COUNT_BITS-1:0] count,
                                         logic [dspg_pkg::COUNT_BITS-1:0] queued);
        logic [dspg_pkg::COUNT_BITS-1:0] magnitude;
        motor_t                          n;
        n = m;
        magnitude    = count[dspg_pkg::COUNT_BITS-1] ? (~count + 1'b1) : count;
        n.remaining  = dspg_pkg::REM_BITS'(magnitude) * dspg_pkg::REM_BITS'(steps_per_unit);
        n.dir        = !count[dspg_pkg::COUNT_BITS-1] && (count != '0);
        n.idle_timer = step_delay;
        n.pending    = queued;
        return n;
    endfunction

    function automatic motor_t after_tick(motor_t m);
        motor_t n;
        n = m;
        n.stopped = 1'b0;
        if (m.remaining != '0)
        begin
            n.step      = ~m.remaining[0];
            n.remaining = m.remaining - 1'b1;
            n.stopped   = (n.remaining == '0) && (m.pending == '0);
        end
        else
        begin
            n.step = 1'b0;
            if (n.idle_timer != '0)
                n.idle_timer = n.idle_timer - 1'b1;
            // queued move starts and the queue empties
            if (n.idle_timer == '0)
                n = with_move(n, n.pending, '0);
        end
        return n;
    endfunction

    task automatic compare_line(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
            level_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        levels_t want;
        if (!rst_n)
        begin
            step_delay     = dspg_pkg::STEP_DELAY_RESET;
            steps_per_unit = dspg_pkg::STEPS_PER_UNIT_RESET;
            left_motor     = '0;
            right_motor    = '0;
            expected_levels_q.delete();
            results_checked <= 0;
            level_errors    = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_levels_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %0b%0b%0b%0b%0b%0b",
                             $time, left_step, left_dir, right_step, right_dir,
                             left_stopped, right_stopped);
                    level_errors++;
                end
                else
                begin
                    want = expected_levels_q.pop_front();
                    compare_line("left_step", want.left_step, left_step);
                    compare_line("left_dir", want.left_dir, left_dir);
                    compare_line("right_step", want.right_step, right_step);
                    compare_line("right_dir", want.right_dir, right_dir);
                    compare_line("left_stopped", want.left_stopped, left_stopped);
                    compare_line("right_stopped", want.right_stopped, right_stopped);
                end
                results_checked <= results_checked + 1;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dspg_pkg::CFG_STEP_DELAY:
                        step_delay = cfg_data;
                    dspg_pkg::CFG_STEPS_PER_UNIT:
                        steps_per_unit = cfg_data[dspg_pkg::SPU_BITS-1:0];
                    default: ;
                endcase
            end

            if (req_valid && req_ready)
            begin
                left_motor.stopped  = 1'b0;
                right_motor.stopped = 1'b0;
                case (operation)
                    dspg_pkg::OP_TICK:
                    begin
                        left_motor  = after_tick(left_motor);
                        right_motor = after_tick(right_motor);
                    end
                    dspg_pkg::OP_MOVE_LEFT:
                        left_motor = with_move(left_motor, move_count, queued_count);
                    dspg_pkg::OP_MOVE_RIGHT:
                        right_motor = with_move(right_motor, move_count, queued_count);
                    default: ;
                endcase
                expected_levels_q.push_back('{left_motor.step, left_motor.dir,
                                              right_motor.step, right_motor.dir,
                                              left_motor.stopped, right_motor.stopped});
            end
        end
    end

endmodule

FILE: tb/dual_stepper_pulse_generator_core_tb.sv
// stimulus, handshake timing and verdict for the dual stepper pulse generator
module dual_stepper_pulse_generator_core_tb;

    // operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_COUNT       = 9;
    localparam int PHASE_REQUESTS    = 148;

    logic                                   clk           = 1'b0;
    logic                                   rst_n         = 1'b0;
    logic                                   req_valid     = 1'b0;
    logic                                   req_ready;
    logic [1:0]                             operation     = dspg_pkg::OP_TICK;
    logic signed [dspg_pkg::COUNT_BITS-1:0] move_count    = '0;
    logic signed [dspg_pkg::COUNT_BITS-1:0] queued_count  = '0;
    logic                                   res_valid;
    logic                                   res_ready     = 1'b0;
    logic                                   left_step;
    logic                                   left_dir;
    logic                                   right_step;
    logic                                   right_dir;
    logic                                   left_stopped;
    logic                                   right_stopped;
    logic                                   cfg_valid     = 1'b0;
    logic                                   cfg_ready;
    logic [dspg_pkg::CFG_INDEX_BITS-1:0]    cfg_index     = dspg_pkg::CFG_STEP_DELAY;
    logic [dspg_pkg::WAIT_BITS-1:0]         cfg_data      = '0;

    int   results_checked;
    int   level_errors;
    int   requests_sent = 0;
    int   ready_hold    = 0;
    // when set, neither side idles
    logic steady        = 1'b0;

    // register settings per random phase: low and high extremes included;
    // the last two phases draw their settings at random
    int delay_plan[PHASE_COUNT] = '{3, 0, 65535, 1, 7, 0, 20, 0, 0};
    int spu_plan[PHASE_COUNT]   = '{1, 2, 255, 1, 3, 1, 5, 0, 0};

    always #6 clk = ~clk;

    dual_stepper_pulse_generator_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .operation     (operation),
        .move_count    (move_count),
        .queued_count  (queued_count),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .left_step     (left_step),
        .left_dir      (left_dir),
        .right_step    (right_step),
        .right_dir     (right_dir),
        .left_stopped  (left_stopped),
        .right_stopped (right_stopped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // watches all three channels, predicts every result and counts mismatches
    dual_stepper_pulse_generator_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .operation       (operation),
        .move_count      (move_count),
        .queued_count    (queued_count),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .left_step       (left_step),
        .left_dir        (left_dir),
        .right_step      (right_step),
        .right_dir       (right_dir),
        .left_stopped    (left_stopped),
        .right_stopped   (right_stopped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .results_checked (results_checked),
        .level_errors    (level_errors)
    );

    // idle length: half the time none, mostly short, now and then long
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // move counts: mostly tiny so runs end and queued moves start,
    // some medium, some anywhere in the signed range
    function automatic logic [dspg_pkg::COUNT_BITS-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return dspg_pkg::COUNT_BITS'(int'($urandom_range(0, 6)) - 3);
        else if (roll < 8)
            return dspg_pkg::COUNT_BITS'(int'($urandom_range(0, 40)) - 20);
        else
            return dspg_pkg::COUNT_BITS'($urandom);
    endfunction

    // result side: ready stays high for a random stretch, then may stall
    always @(posedge clk or negedge rst_n)
    begin : result_side
        int stall;
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (!res_ready)
        begin
            res_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
        else
        begin
            stall = idle_length();
            if (stall != 0)
            begin
                res_ready  <= 1'b0;
                ready_hold <= stall - 1;
            end
        end
    end

    // one request: optional gap, then hold valid and payload until accepted;
    // valid is only lowered when a gap follows, never lowered and raised in one step
    task automatic issue(input logic [1:0] op, input logic [dspg_pkg::COUNT_BITS-1:0] count,
                         input logic [dspg_pkg::COUNT_BITS-1:0] queued);
        int gap;
        gap = idle_length();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        operation    <= op;
        move_count   <= count;
        queued_count <= queued;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        requests_sent++;
    endtask

    // stop requesting and wait until every accepted request has its result
    task automatic drain();
        req_valid <= 1'b0;
        while (results_checked != requests_sent) @(posedge clk);
    endtask

    // both registers written back to back while the block is idle
    task automatic set_registers(input int delay, input int spu);
        drain();
        // let the two-stage pipeline settle before touching the registers
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= dspg_pkg::CFG_STEP_DELAY;
        cfg_data  <= dspg_pkg::WAIT_BITS'(delay);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= dspg_pkg::CFG_STEPS_PER_UNIT;
        cfg_data  <= dspg_pkg::WAIT_BITS'(spu);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random request mix: ticks dominate so runs play out, moves on both
    // channels with queued follow-ups, a few ignored operation codes
    task automatic random_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            issue(dspg_pkg::OP_TICK, dspg_pkg::COUNT_BITS'($urandom),
                  dspg_pkg::COUNT_BITS'($urandom));
        else if (roll < 78)
            issue(dspg_pkg::OP_MOVE_LEFT, pick_count(), pick_count());
        else if (roll < 96)
            issue(dspg_pkg::OP_MOVE_RIGHT, pick_count(), pick_count());
        else
            issue(OP_UNUSED, dspg_pkg::COUNT_BITS'($urandom),
                  dspg_pkg::COUNT_BITS'($urandom));
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: idle ticks, ignored code, full-scale moves
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(OP_UNUSED, 16'sh7fff, 16'sh8000);
        issue(dspg_pkg::OP_MOVE_LEFT, 16'sh7fff, 16'sh8000);
        issue(dspg_pkg::OP_MOVE_RIGHT, 16'sh8000, 16'sh7fff);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, 16'shffff, 16'shffff);
        // zero count drives direction low and loads nothing
        issue(dspg_pkg::OP_MOVE_LEFT, '0, '0);
        issue(dspg_pkg::OP_MOVE_RIGHT, 16'shffff, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);

        // zero delay with zero half-steps per unit: queued moves start at once, empty
        set_registers(0, 0);
        issue(dspg_pkg::OP_MOVE_LEFT, 16'sd5, 16'sd3);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_MOVE_RIGHT, -16'sd7, 16'sd2);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);

        // one half-step per unit: short runs, stop pulses, queued follow-up
        set_registers(0, 1);
        issue(dspg_pkg::OP_MOVE_LEFT, 16'sd1, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_MOVE_RIGHT, 16'sd2, -16'sd1);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);
        // move on a busy channel overwrites the run
        issue(dspg_pkg::OP_MOVE_LEFT, 16'sd3, '0);
        issue(dspg_pkg::OP_MOVE_LEFT, -16'sd2, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);
        issue(dspg_pkg::OP_TICK, '0, '0);

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase >= PHASE_COUNT - 2)
                set_registers($urandom_range(0, 12), $urandom_range(1, 8));
            else
                set_registers(delay_plan[phase], spu_plan[phase]);
            // a couple of phases run with both sides at full rate
            steady = (phase == 3) || (phase == 6);
            for (n = 0; n < PHASE_REQUESTS; n++)
                random_request();
        end
        steady = 1'b0;

        drain();
        // keep clocking so a stray result would still show up
        repeat (8) @(posedge clk);
        if (level_errors == 0)
            $display("dual_stepper_pulse_generator_core verification clean");
        else
            $display("dual_stepper_pulse_generator_core verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #6000000;
        $display("dual_stepper_pulse_generator_core verification failed");
        $finish;
    end

endmodule
